/* rtl/tvm_pkg.sv */
// ----------------------------------------------------------------------------
// tvm_pkg
// shared types, codes and helpers of the teaching word machine
// ----------------------------------------------------------------------------
package tvm_pkg;

  localparam int unsigned MemWords = 1024;
  localparam int unsigned AddrW    = $clog2(MemWords);
  localparam int unsigned WordW    = 32;

  localparam logic [1:0] KindLoad  = 2'd0;
  localparam logic [1:0] KindStart = 2'd1;
  localparam logic [1:0] KindStep  = 2'd2;

  localparam logic [2:0] StAccepted = 3'd0;
  localparam logic [2:0] StExecuted = 3'd1;
  localparam logic [2:0] StHalted   = 3'd2;
  localparam logic [2:0] StUnknown  = 3'd3;
  localparam logic [2:0] StDivZero  = 3'd4;
  localparam logic [2:0] StNotRun   = 3'd5;

  localparam logic [1:0] FlagPos  = 2'd0;
  localparam logic [1:0] FlagZero = 2'd1;
  localparam logic [1:0] FlagNeg  = 2'd2;

  localparam logic [4:0] OpHalt  = 5'd0;
  localparam logic [4:0] OpLoad  = 5'd1;
  localparam logic [4:0] OpStore = 5'd2;
  localparam logic [4:0] OpRead  = 5'd3;
  localparam logic [4:0] OpWrite = 5'd4;
  localparam logic [4:0] OpCopy  = 5'd5;
  localparam logic [4:0] OpPush  = 5'd6;
  localparam logic [4:0] OpPop   = 5'd7;
  localparam logic [4:0] OpJump  = 5'd8;
  localparam logic [4:0] OpJz    = 5'd9;
  localparam logic [4:0] OpJnz   = 5'd10;
  localparam logic [4:0] OpJn    = 5'd11;
  localparam logic [4:0] OpJnn   = 5'd12;
  localparam logic [4:0] OpCall  = 5'd13;
  localparam logic [4:0] OpRet   = 5'd14;
  localparam logic [4:0] OpAnd   = 5'd15;
  localparam logic [4:0] OpOr    = 5'd16;
  localparam logic [4:0] OpNot   = 5'd17;
  localparam logic [4:0] OpXor   = 5'd18;
  localparam logic [4:0] OpAdd   = 5'd19;
  localparam logic [4:0] OpSub   = 5'd20;
  localparam logic [4:0] OpMul   = 5'd21;
  localparam logic [4:0] OpDiv   = 5'd22;
  localparam logic [4:0] OpMod   = 5'd23;
  localparam logic [4:0] OpCmp   = 5'd24;
  localparam logic [4:0] OpTest  = 5'd25;

  typedef enum logic [1:0] {
    MD_MUL = 2'd0,
    MD_DIV = 2'd1,
    MD_MOD = 2'd2
  } md_op_e;

  function automatic logic [1:0] flag_of(input logic [WordW-1:0] v);
    if (v == '0) begin
      return FlagZero;
    end
    return v[WordW-1] ? FlagNeg : FlagPos;
  endfunction

endpackage

/* rtl/tvm_ram.sv */
// ----------------------------------------------------------------------------
// tvm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tvm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/tvm_muldiv.sv */
// ----------------------------------------------------------------------------
// tvm_muldiv
// bit-serial multiply and signed truncating divide / modulo, one bit a cycle
// ----------------------------------------------------------------------------
module tvm_muldiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tvm_pkg::md_op_e     op_i,
  input  logic [31:0]         a_i,
  input  logic [31:0]         b_i,
  output logic                done_o,
  output logic [31:0]         result_o
);
  import tvm_pkg::*;

  logic        busy_q, done_q, neg_q;
  logic [4:0]  cnt_q;
  md_op_e      op_q;
  logic [31:0] acc_q, x_q, y_q;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh = {acc_q, x_q[31]};
  assign fits   = rem_sh >= {1'b0, y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      op_q   <= MD_MUL;
      acc_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        op_q   <= op_i;
        acc_q  <= '0;
        if (op_i == MD_MUL) begin
          x_q   <= a_i;
          y_q   <= b_i;
          neg_q <= 1'b0;
        end else begin
          // work on magnitudes, fix the sign at the end
          x_q   <= a_i[31] ? 32'(-a_i) : a_i;
          y_q   <= b_i[31] ? 32'(-b_i) : b_i;
          neg_q <= (op_i == MD_DIV) ? (a_i[31] ^ b_i[31]) : a_i[31];
        end
      end else if (busy_q) begin
        if (op_q == MD_MUL) begin
          if (y_q[0]) begin
            acc_q <= acc_q + x_q;
          end
          x_q <= {x_q[30:0], 1'b0};
          y_q <= {1'b0, y_q[31:1]};
        end else begin
          if (fits) begin
            acc_q <= 32'(rem_sh - {1'b0, y_q});
          end else begin
            acc_q <= rem_sh[31:0];
          end
          x_q <= {x_q[30:0], fits};
        end
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (op_q)
      MD_DIV:  result_o = neg_q ? 32'(-x_q) : x_q;
      MD_MOD:  result_o = neg_q ? 32'(-acc_q) : acc_q;
      default: result_o = acc_q;
    endcase
  end

  assign done_o = done_q;

endmodule

/* rtl/teaching_vm_core.sv */
// ----------------------------------------------------------------------------
// teaching_vm_core
// small word machine: four registers, word memory, stack, condition flag
// ----------------------------------------------------------------------------
// Each accepted beat gives exactly one result beat. A load, a start, an unused
// kind or a step while stopped goes from S_IDLE straight to S_EMIT. A step
// fetches the instruction and its two operand words one after another through
// the single read port of the word memory (S_F0 to S_F3, then S_EXEC); load,
// pop and ret add one more memory read in S_LDW, and mul, and div and mod with
// a nonzero divisor, wait in S_ARITH on the bit-serial multiply/divide unit.
// The block takes no new beat while an item is at work; a finished result waits
// in the output register, and a stalled output holds the next item in S_EMIT.
module teaching_vm_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                kind_i,
  input  logic [9:0]                address_i,
  input  logic signed [31:0]        word_data_i,
  input  logic [9:0]                stack_start_i,
  output logic                      res_valid_o,
  input  logic                      res_stall_i,
  output logic [2:0]                status_o,
  output logic [4:0]                opcode_o,
  output logic [9:0]                pc_o,
  output logic [9:0]                stack_pointer_o,
  output logic [1:0]                flags_o,
  output logic signed [31:0]        reg_zero_o,
  output logic signed [31:0]        reg_one_o,
  output logic signed [31:0]        reg_two_o,
  output logic signed [31:0]        reg_three_o,
  output logic                      out_valid_o,
  output logic signed [31:0]        out_value_o
);
  import tvm_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_F0    = 9'b000000010,
    S_F1    = 9'b000000100,
    S_F2    = 9'b000001000,
    S_F3    = 9'b000010000,
    S_EXEC  = 9'b000100000,
    S_LDW   = 9'b001000000,
    S_ARITH = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

  state_e            state_q;
  logic [AddrW-1:0]  pc_q, sp_q;
  logic [1:0]        flag_q;
  logic              running_q;
  logic [31:0]       r0_q, r1_q, r2_q, r3_q;
  logic [31:0]       code_q, w1_q, w2_q, data_q;
  logic [2:0]        st_q;
  logic [4:0]        opc_q;
  logic              ov_q;
  logic [31:0]       oval_q;

  logic              rv_q;
  logic [2:0]        o_status_q;
  logic [4:0]        o_opc_q;
  logic [AddrW-1:0]  o_pc_q, o_sp_q;
  logic [1:0]        o_flag_q;
  logic [31:0]       o_r0_q, o_r1_q, o_r2_q, o_r3_q, o_oval_q;
  logic              o_ov_q;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata, ram_rdata;

  logic              md_start, md_done;
  md_op_e            md_op;
  logic [31:0]       md_result;

  logic              accept;
  logic [31:0]       a_val, b_val, alu_res;
  logic [4:0]        opc;
  logic              code_bad;
  logic [AddrW-1:0]  next2, next3, opnd, mem_tgt, jmp_tgt, sp_dec;
  logic              take;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    case (w1_q[1:0])
      2'd0:    a_val = r0_q;
      2'd1:    a_val = r1_q;
      2'd2:    a_val = r2_q;
      default: a_val = r3_q;
    endcase
    case (w2_q[1:0])
      2'd0:    b_val = r0_q;
      2'd1:    b_val = r1_q;
      2'd2:    b_val = r2_q;
      default: b_val = r3_q;
    endcase
  end

  assign code_bad = code_q[31] || (code_q > 32'd25);
  assign opc      = code_q[4:0];
  assign opnd     = pc_q + AddrW'(1);
  assign next2    = pc_q + AddrW'(2);
  assign next3    = pc_q + AddrW'(3);
  assign mem_tgt  = next3 + w2_q[AddrW-1:0];
  assign jmp_tgt  = opnd + w1_q[AddrW-1:0];
  assign sp_dec   = sp_q - AddrW'(1);

  always_comb begin
    case (opc)
      OpJz:    take = (flag_q == FlagZero);
      OpJnz:   take = (flag_q != FlagZero);
      OpJn:    take = (flag_q == FlagNeg);
      default: take = (flag_q != FlagNeg);
    endcase
  end

  always_comb begin
    case (opc)
      OpAnd, OpTest: alu_res = a_val & b_val;
      OpOr:          alu_res = a_val | b_val;
      OpXor:         alu_res = a_val ^ b_val;
      OpAdd:         alu_res = a_val + b_val;
      OpNot:         alu_res = ~a_val;
      OpCopy:        alu_res = b_val;
      default:       alu_res = a_val - b_val;
    endcase
  end

  always_comb begin
    case (opc)
      OpDiv:   md_op = MD_DIV;
      OpMod:   md_op = MD_MOD;
      default: md_op = MD_MUL;
    endcase
  end

  assign md_start = (state_q == S_EXEC) && !code_bad &&
                    (opc == OpMul || ((opc == OpDiv || opc == OpMod) && b_val != '0));

  // memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = address_i[AddrW-1:0];
    ram_wdata = word_data_i;
    ram_raddr = pc_q;
    case (state_q)
      S_IDLE: begin
        ram_we = accept && (kind_i == KindLoad);
      end
      S_F1: ram_raddr = opnd;
      S_F2: ram_raddr = next2;
      S_EXEC: begin
        if (opc == OpPop || opc == OpRet) begin
          ram_raddr = sp_q;
        end else begin
          ram_raddr = mem_tgt;
        end
        if (!code_bad) begin
          case (opc)
            OpStore: begin
              ram_we    = 1'b1;
              ram_waddr = mem_tgt;
              ram_wdata = a_val;
            end
            OpPush: begin
              ram_we    = 1'b1;
              ram_waddr = sp_dec;
              ram_wdata = a_val;
            end
            OpCall: begin
              ram_we    = 1'b1;
              ram_waddr = sp_dec;
              ram_wdata = 32'(next2);
            end
            default: ram_we = 1'b0;
          endcase
        end
      end
      default: ram_raddr = pc_q;
    endcase
  end

  tvm_ram #(
    .Width(WordW),
    .Depth(MemWords)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  tvm_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .op_i    (md_op),
    .a_i     (a_val),
    .b_i     (b_val),
    .done_o  (md_done),
    .result_o(md_result)
  );

  logic [31:0] r0_d, r1_d, r2_d, r3_d, wval;
  logic        wen;

  always_comb begin
    r0_d = r0_q;
    r1_d = r1_q;
    r2_d = r2_q;
    r3_d = r3_q;
    wen  = 1'b0;
    wval = alu_res;
    if (state_q == S_EXEC && !code_bad) begin
      case (opc)
        OpRead: begin
          wen  = 1'b1;
          wval = data_q;
        end
        OpCopy, OpAnd, OpOr, OpNot, OpXor, OpAdd, OpSub: wen = 1'b1;
        default: wen = 1'b0;
      endcase
    end else if (state_q == S_LDW && opc != OpRet) begin
      wen  = 1'b1;
      wval = ram_rdata;
    end else if (state_q == S_ARITH && md_done) begin
      wen  = 1'b1;
      wval = md_result;
    end
    if (wen) begin
      case (w1_q[1:0])
        2'd0:    r0_d = wval;
        2'd1:    r1_d = wval;
        2'd2:    r2_d = wval;
        default: r3_d = wval;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pc_q      <= '0;
      sp_q      <= '0;
      flag_q    <= FlagZero;
      running_q <= 1'b0;
      r0_q      <= '0;
      r1_q      <= '0;
      r2_q      <= '0;
      r3_q      <= '0;
      code_q    <= '0;
      w1_q      <= '0;
      w2_q      <= '0;
      data_q    <= '0;
      st_q      <= StAccepted;
      opc_q     <= OpHalt;
      ov_q      <= 1'b0;
      oval_q    <= '0;
      rv_q      <= 1'b0;
      o_status_q <= StAccepted;
      o_opc_q   <= OpHalt;
      o_pc_q    <= '0;
      o_sp_q    <= '0;
      o_flag_q  <= FlagZero;
      o_r0_q    <= '0;
      o_r1_q    <= '0;
      o_r2_q    <= '0;
      o_r3_q    <= '0;
      o_ov_q    <= 1'b0;
      o_oval_q  <= '0;
    end else begin
      r0_q <= r0_d;
      r1_q <= r1_d;
      r2_q <= r2_d;
      r3_q <= r3_d;
      if (rv_q && !res_stall_i && state_q != S_EMIT) begin
        rv_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            st_q   <= StAccepted;
            opc_q  <= OpHalt;
            ov_q   <= 1'b0;
            oval_q <= '0;
            data_q <= word_data_i;
            state_q <= S_EMIT;
            if (kind_i == KindStart) begin
              pc_q      <= address_i[AddrW-1:0];
              sp_q      <= stack_start_i[AddrW-1:0];
              running_q <= 1'b1;
            end else if (kind_i == KindStep) begin
              if (running_q) begin
                state_q <= S_F0;
              end else begin
                st_q <= StNotRun;
              end
            end
          end
        end
        S_F0: state_q <= S_F1;
        S_F1: begin
          code_q  <= ram_rdata;
          state_q <= S_F2;
        end
        S_F2: begin
          w1_q    <= ram_rdata;
          state_q <= S_F3;
        end
        S_F3: begin
          w2_q    <= ram_rdata;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= S_EMIT;
          st_q    <= StExecuted;
          opc_q   <= opc;
          if (code_bad) begin
            st_q      <= StUnknown;
            opc_q     <= OpHalt;
            running_q <= 1'b0;
          end else if (opc == OpHalt) begin
            st_q      <= StHalted;
            running_q <= 1'b0;
          end else if ((opc == OpDiv || opc == OpMod) && b_val == '0) begin
            st_q      <= StDivZero;
            running_q <= 1'b0;
          end else begin
            case (opc)
              OpLoad, OpPop, OpRet: state_q <= S_LDW;
              OpMul, OpDiv, OpMod:  state_q <= S_ARITH;
              OpStore: pc_q <= next3;
              OpRead:  pc_q <= next2;
              OpWrite: begin
                ov_q   <= 1'b1;
                oval_q <= a_val;
                pc_q   <= next2;
              end
              OpPush: begin
                sp_q <= sp_dec;
                pc_q <= next2;
              end
              OpJump: pc_q <= jmp_tgt;
              OpJz, OpJnz, OpJn, OpJnn: pc_q <= take ? jmp_tgt : next2;
              OpCall: begin
                sp_q <= sp_dec;
                pc_q <= jmp_tgt;
              end
              OpNot: begin
                flag_q <= flag_of(alu_res);
                pc_q   <= next2;
              end
              default: begin
                flag_q <= flag_of(alu_res);
                pc_q   <= next3;
              end
            endcase
          end
        end
        S_LDW: begin
          state_q <= S_EMIT;
          case (opc)
            OpLoad: pc_q <= next3;
            OpPop: begin
              sp_q <= sp_q + AddrW'(1);
              pc_q <= next2;
            end
            default: begin
              sp_q <= sp_q + AddrW'(1);
              pc_q <= ram_rdata[AddrW-1:0];
            end
          endcase
        end
        S_ARITH: begin
          if (md_done) begin
            flag_q  <= flag_of(md_result);
            pc_q    <= next3;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!rv_q || !res_stall_i) begin
            rv_q       <= 1'b1;
            o_status_q <= st_q;
            o_opc_q    <= opc_q;
            o_pc_q     <= pc_q;
            o_sp_q     <= sp_q;
            o_flag_q   <= flag_q;
            o_r0_q     <= r0_q;
            o_r1_q     <= r1_q;
            o_r2_q     <= r2_q;
            o_r3_q     <= r3_q;
            o_ov_q     <= ov_q;
            o_oval_q   <= oval_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o     = rv_q;
  assign status_o        = o_status_q;
  assign opcode_o        = o_opc_q;
  assign pc_o            = 10'(o_pc_q);
  assign stack_pointer_o = 10'(o_sp_q);
  assign flags_o         = o_flag_q;
  assign reg_zero_o      = o_r0_q;
  assign reg_one_o       = o_r1_q;
  assign reg_two_o       = o_r2_q;
  assign reg_three_o     = o_r3_q;
  assign out_valid_o     = o_ov_q;
  assign out_value_o     = o_oval_q;

endmodule

/* rtl/tvm_checker.sv */
// ----------------------------------------------------------------------------
// tvm_checker
// port-level checks of the word machine, bound to the top level
// ----------------------------------------------------------------------------
module tvm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        res_valid_o,
  input logic        res_stall_i,
  input logic [2:0]  status_o,
  input logic [4:0]  opcode_o,
  input logic        out_valid_o
);
  import tvm_pkg::*;

  // a stalled result beat stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o)
    else $error("result beat dropped while stalled");

  // one item at a time: an accepted beat closes the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is at work");

  // only an executed write emits a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_valid_o |-> status_o == StExecuted && opcode_o == OpWrite)
    else $error("value emitted by something other than a write");

  // no opcode is reported for an item that executed no instruction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (status_o == StAccepted || status_o == StNotRun ||
                    status_o == StUnknown) |-> opcode_o == OpHalt)
    else $error("opcode reported for an item that executed none");

endmodule

bind teaching_vm_core tvm_checker u_tvm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .res_valid_o(res_valid_o),
  .res_stall_i(res_stall_i),
  .status_o   (status_o),
  .opcode_o   (opcode_o),
  .out_valid_o(out_valid_o)
);
